/* sv/tkf_pkg.sv */
`default_nettype none
package tkf_pkg;

    // Field widths fixed by the sample and result formats.
    localparam int RAW_W     = 16;
    localparam int DIFF_W    = 17;
    localparam int DT_W      = 20;
    localparam int SQ_W      = 32;
    localparam int SUMSQ_W   = 33;
    localparam int ANGLE_W   = 32;
    localparam int EST_W     = 32;
    localparam int VAR_W     = 31;
    localparam int MEAS_W    = 24;
    localparam int LANES     = 2;
    localparam int ATAN_LEN  = 24;

    // Configuration register indexes.
    localparam logic [2:0] CFG_ACCEL_X_OFFSET = 3'd0;
    localparam logic [2:0] CFG_ACCEL_Y_OFFSET = 3'd1;
    localparam logic [2:0] CFG_ACCEL_Z_OFFSET = 3'd2;
    localparam logic [2:0] CFG_GYRO_X_OFFSET  = 3'd3;
    localparam logic [2:0] CFG_GYRO_Y_OFFSET  = 3'd4;

    // Work handed to the angle unit of one lane.
    typedef struct packed {
        logic signed [DIFF_W-1:0] num;
        logic [SUMSQ_W-1:0]       sumsq;
    } tilt_cmd_t;

    // Work handed to the Kalman unit of one lane.
    typedef struct packed {
        logic signed [DIFF_W-1:0] rate;
        logic [DT_W-1:0]          dt;
    } kal_cmd_t;

    // CORDIC angle table: atan(2^-i) in degrees, scaled by 2^24.
    function automatic logic [29:0] atan_deg_q24(input logic [4:0] idx);
        logic [29:0] v;
        case (idx)
            5'd0:  v = 30'd754974720;
            5'd1:  v = 30'd445687602;
            5'd2:  v = 30'd235489088;
            5'd3:  v = 30'd119537938;
            5'd4:  v = 30'd60000934;
            5'd5:  v = 30'd30029717;
            5'd6:  v = 30'd15018523;
            5'd7:  v = 30'd7509720;
            5'd8:  v = 30'd3754917;
            5'd9:  v = 30'd1877466;
            5'd10: v = 30'd938734;
            5'd11: v = 30'd469367;
            5'd12: v = 30'd234684;
            5'd13: v = 30'd117342;
            5'd14: v = 30'd58671;
            5'd15: v = 30'd29335;
            5'd16: v = 30'd14668;
            5'd17: v = 30'd7334;
            5'd18: v = 30'd3667;
            5'd19: v = 30'd1833;
            5'd20: v = 30'd917;
            5'd21: v = 30'd458;
            5'd22: v = 30'd229;
            5'd23: v = 30'd115;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

    // Saturate a wide signed value to 32 bits.
    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < -64'sd2147483648) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

/* sv/tkf_div.sv */
`default_nettype none
// Restoring divider, one quotient bit per cycle.
module tkf_div #(
    parameter int N_W = 47,
    parameter int D_W = 32
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           start,
    input  wire logic [N_W-1:0] dividend,
    input  wire logic [D_W-1:0] divisor,
    output logic                done,
    output logic [N_W-1:0]      quotient
);
    localparam int CNT_W = $clog2(N_W + 1);

    logic             run_reg, run_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [N_W-1:0]   quo_reg, quo_next;
    logic [D_W-1:0]   rem_reg, rem_next;
    logic [D_W-1:0]   den_reg, den_next;
    logic [D_W:0]     trial;
    logic             fits;

    // One shift-and-subtract step per cycle.
    always_comb begin
        trial     = {rem_reg, quo_reg[N_W-1]};
        fits      = trial >= {1'b0, den_reg};
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        if (start) begin
            run_next = 1'b1;
            cnt_next = CNT_W'(N_W);
            quo_next = dividend;
            rem_next = '0;
            den_next = divisor;
        end else if (run_reg) begin
            rem_next = fits ? D_W'(trial - {1'b0, den_reg}) : trial[D_W-1:0];
            quo_next = {quo_reg[N_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule
`default_nettype wire

/* sv/tkf_tilt.sv */
`default_nettype none
// Tilt angle of one lane: bit-pair square root, then CORDIC vectoring.
module tkf_tilt #(
    parameter int CORDIC_STEPS  = 16,
    parameter int FRACTION_BITS = 16
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 start,
    input  wire tkf_pkg::tilt_cmd_t   cmd,
    output logic                      fin,
    output logic signed [tkf_pkg::ANGLE_W-1:0] angle
);
    localparam int RT_W = 50;
    localparam int CW   = 37;
    localparam int ZW   = 34;
    localparam int SH   = 24 - FRACTION_BITS;
    localparam int ROUND_ADD = (1 << SH) >> 1;
    localparam logic signed [tkf_pkg::ANGLE_W-1:0] NINETY =
        tkf_pkg::ANGLE_W'(90 << FRACTION_BITS);
    localparam logic signed [ZW-1:0] NINETY_Z = ZW'(90 << FRACTION_BITS);

    localparam logic [2:0] TS_IDLE  = 3'd0;
    localparam logic [2:0] TS_SQRT  = 3'd1;
    localparam logic [2:0] TS_SETUP = 3'd2;
    localparam logic [2:0] TS_CORD  = 3'd3;
    localparam logic [2:0] TS_ROUND = 3'd4;
    localparam logic [2:0] TS_DONE  = 3'd5;

    logic [2:0] state_reg, state_next;
    logic signed [tkf_pkg::DIFF_W-1:0] num_reg, num_next;
    logic [RT_W-1:0] v_reg, v_next, res_reg, res_next, bit_reg, bit_next;
    logic [RT_W-1:0] trial;
    logic signed [CW-1:0] x_reg, x_next, y_reg, y_next, dx, dy;
    logic signed [ZW-1:0] z_reg, z_next, at, zs, zr;
    logic [4:0] cnt_reg, cnt_next;
    logic signed [tkf_pkg::ANGLE_W-1:0] angle_reg, angle_next;

    always_comb begin
        trial      = res_reg + bit_reg;
        dx         = y_reg >>> cnt_reg;
        dy         = x_reg >>> cnt_reg;
        at         = ZW'(tkf_pkg::atan_deg_q24(cnt_reg));
        zs         = z_reg + ZW'(ROUND_ADD);
        zr         = zs >>> SH;
        state_next = state_reg;
        num_next   = num_reg;
        v_next     = v_reg;
        res_next   = res_reg;
        bit_next   = bit_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        z_next     = z_reg;
        cnt_next   = cnt_reg;
        angle_next = angle_reg;
        unique case (state_reg) inside
            TS_IDLE, TS_DONE: begin
            end
            // Floor square root, two radicand bits per cycle.
            TS_SQRT: begin
                if (bit_reg == '0) begin
                    state_next = TS_SETUP;
                end else begin
                    if (v_reg >= trial) begin
                        v_next   = v_reg - trial;
                        res_next = (res_reg >> 1) + bit_reg;
                    end else begin
                        res_next = res_reg >> 1;
                    end
                    bit_next = bit_reg >> 2;
                end
            end
            // Zero root or zero numerator give a fixed angle.
            TS_SETUP: begin
                if (res_reg == '0) begin
                    if (num_reg > 0) begin
                        angle_next = NINETY;
                    end else if (num_reg < 0) begin
                        angle_next = -NINETY;
                    end else begin
                        angle_next = '0;
                    end
                    state_next = TS_DONE;
                end else if (num_reg == '0) begin
                    angle_next = '0;
                    state_next = TS_DONE;
                end else begin
                    x_next     = CW'(res_reg) <<< 8;
                    y_next     = CW'(num_reg) <<< 16;
                    z_next     = '0;
                    cnt_next   = '0;
                    state_next = TS_CORD;
                end
            end
            // One vectoring rotation per cycle.
            TS_CORD: begin
                if (y_reg > 0) begin
                    x_next = x_reg + dx;
                    y_next = y_reg - dy;
                    z_next = z_reg + at;
                end else begin
                    x_next = x_reg - dx;
                    y_next = y_reg + dy;
                    z_next = z_reg - at;
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == 5'(CORDIC_STEPS - 1)) begin
                    state_next = TS_ROUND;
                end
            end
            // Round to the output fraction and clamp to plus or minus ninety.
            TS_ROUND: begin
                if (zr > NINETY_Z) begin
                    angle_next = NINETY;
                end else if (zr < -NINETY_Z) begin
                    angle_next = -NINETY;
                end else begin
                    angle_next = zr[tkf_pkg::ANGLE_W-1:0];
                end
                state_next = TS_DONE;
            end
            default: state_next = TS_IDLE;
        endcase
        if (start) begin
            num_next   = cmd.num;
            v_next     = RT_W'(cmd.sumsq) << 16;
            res_next   = '0;
            bit_next   = RT_W'(1) << (RT_W - 2);
            state_next = TS_SQRT;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= TS_IDLE;
        end else begin
            state_reg <= state_next;
        end
        num_reg   <= num_next;
        v_reg     <= v_next;
        res_reg   <= res_next;
        bit_reg   <= bit_next;
        x_reg     <= x_next;
        y_reg     <= y_next;
        z_reg     <= z_next;
        cnt_reg   <= cnt_next;
        angle_reg <= angle_next;
    end

    assign fin   = (state_reg == TS_DONE);
    assign angle = angle_reg;

endmodule
`default_nettype wire

/* sv/tkf_kalman.sv */
`default_nettype none
// Scalar Kalman step of one lane; the gain uses a serial divider and the gyro
// scaling by 1/131 uses a reciprocal multiply.
module tkf_kalman #(
    parameter int FRACTION_BITS = 16
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 start,
    input  wire tkf_pkg::kal_cmd_t    cmd,
    input  wire logic                 meas_ok,
    input  wire logic signed [tkf_pkg::ANGLE_W-1:0] meas,
    output logic                      done,
    output logic signed [tkf_pkg::EST_W-1:0] est
);
    localparam int ONE  = 1 << FRACTION_BITS;
    localparam int N_W  = FRACTION_BITS + 31;
    localparam int D_W  = 32;
    localparam int KW   = FRACTION_BITS + 1;
    localparam int RDW  = 38;
    localparam int MAGW = 37;
    localparam int XW   = MAGW + FRACTION_BITS + 1;
    localparam int DSQW = 40;
    localparam int QW   = 41;
    localparam int SW   = N_W + 2;
    localparam int DFW  = 33;
    localparam int CPW  = FRACTION_BITS + 35;
    localparam int PPW  = FRACTION_BITS + 32;
    localparam int QADD = 1 << (35 - FRACTION_BITS);
    localparam int QSH  = 36 - FRACTION_BITS;
    // The scaled gyro term fits TW bits; floor(t / 131) = (t * RECIP) >> RS for all of them.
    localparam int TW   = FRACTION_BITS + 16;
    localparam int RS   = TW + 8;
    localparam int RW   = TW + 1;
    localparam longint unsigned RECIP = ((64'd1 << RS) + 64'd130) / 64'd131;
    localparam logic [tkf_pkg::VAR_W-1:0] VAR_RESET =
        tkf_pkg::VAR_W'(4 << FRACTION_BITS);
    localparam logic [tkf_pkg::VAR_W-1:0] VAR_MAX = '1;

    localparam logic [3:0] KS_IDLE  = 4'd0;
    localparam logic [3:0] KS_MUL   = 4'd1;
    localparam logic [3:0] KS_PREP  = 4'd2;
    localparam logic [3:0] KS_RECIP = 4'd3;
    localparam logic [3:0] KS_DIVK  = 4'd4;
    localparam logic [3:0] KS_WAIT  = 4'd5;
    localparam logic [3:0] KS_MUL2  = 4'd6;
    localparam logic [3:0] KS_FIN   = 4'd7;
    localparam logic [3:0] KS_DONE  = 4'd8;

    logic [3:0] state_reg, state_next;
    logic signed [tkf_pkg::EST_W-1:0] est_reg, est_next;
    logic [tkf_pkg::VAR_W-1:0] var_reg, var_next;
    logic signed [tkf_pkg::DIFF_W-1:0] rate_reg;
    logic [tkf_pkg::DT_W-1:0] dt_reg;
    logic signed [RDW-1:0] rd_reg, rd_abs;
    logic [DSQW-1:0] dtsq_reg;
    logic neg_reg;
    logic [tkf_pkg::VAR_W-1:0] p1_reg, p1;
    logic signed [tkf_pkg::EST_W-1:0] x1_reg;
    logic [KW-1:0] k_reg, omk;
    logic signed [DFW-1:0] diff_reg;
    logic signed [CPW-1:0] cp_reg, cp_abs;
    logic [PPW-1:0] pp_reg;
    logic [CPW-1:0] corr;
    logic [XW-1:0] xnum;
    logic [QW-1:0] qterm, p1sum;
    logic [TW-1:0] t_reg, q_reg;
    logic [2*TW:0] qprod;
    logic signed [SW-1:0] delta, x1sum;
    logic signed [63:0] x2sum;
    logic div_start, div_done;
    logic [N_W-1:0] div_dvd, div_quo;
    logic [D_W-1:0] div_dsr;

    tkf_div #(.N_W(N_W), .D_W(D_W)) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dsr),
        .done     (div_done),
        .quotient (div_quo)
    );

    // Gyro increment rounding term, process noise, predicted variance and state, and the correction.
    always_comb begin
        rd_abs = rd_reg[RDW-1] ? -rd_reg : rd_reg;
        xnum   = (XW'(rd_abs[MAGW-1:0]) << FRACTION_BITS) + XW'(131 << 19);
        qprod  = t_reg * RW'(RECIP);
        qterm  = (QW'(dtsq_reg) + QW'(QADD)) >> QSH;
        p1sum  = QW'(var_reg) + qterm;
        p1     = (p1sum > QW'(VAR_MAX)) ? VAR_MAX : p1sum[tkf_pkg::VAR_W-1:0];
        delta  = neg_reg ? -SW'(q_reg) : SW'(q_reg);
        x1sum  = SW'(est_reg) + delta;
        omk    = KW'(ONE) - k_reg;
        cp_abs = cp_reg[CPW-1] ? -cp_reg : cp_reg;
        corr   = (CPW'(cp_abs) + CPW'(ONE / 2)) >> FRACTION_BITS;
        x2sum  = 64'(x1_reg) + (cp_reg[CPW-1] ? -64'(corr) : 64'(corr));
    end

    // The divider computes the gain from the predicted variance.
    assign div_start = (state_reg == KS_RECIP);
    assign div_dvd   = N_W'(p1_reg) << FRACTION_BITS;
    assign div_dsr   = D_W'(p1_reg) + D_W'(9 << FRACTION_BITS);

    always_comb begin
        state_next = state_reg;
        est_next   = est_reg;
        var_next   = var_reg;
        unique case (state_reg) inside
            KS_IDLE, KS_DONE: begin
                if (start) begin
                    state_next = KS_MUL;
                end
            end
            KS_MUL:   state_next = KS_PREP;
            KS_PREP:  state_next = KS_RECIP;
            KS_RECIP: state_next = KS_DIVK;
            KS_DIVK: begin
                if (div_done) begin
                    state_next = KS_WAIT;
                end
            end
            KS_WAIT: begin
                if (meas_ok) begin
                    state_next = KS_MUL2;
                end
            end
            KS_MUL2: state_next = KS_FIN;
            KS_FIN: begin
                est_next   = tkf_pkg::sat32(x2sum);
                var_next   = tkf_pkg::VAR_W'((pp_reg + PPW'(ONE / 2)) >> FRACTION_BITS);
                state_next = KS_DONE;
            end
            default: state_next = KS_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= KS_IDLE;
            est_reg   <= '0;
            var_reg   <= VAR_RESET;
        end else begin
            state_reg <= state_next;
            est_reg   <= est_next;
            var_reg   <= var_next;
        end
        if (start) begin
            rate_reg <= cmd.rate;
            dt_reg   <= cmd.dt;
        end
        if (state_reg == KS_MUL) begin
            rd_reg   <= rate_reg * $signed({1'b0, dt_reg});
            dtsq_reg <= dt_reg * dt_reg;
        end
        if (state_reg == KS_PREP) begin
            neg_reg <= rd_reg[RDW-1];
            p1_reg  <= p1;
            t_reg   <= TW'(xnum >> 20);
        end
        if (state_reg == KS_RECIP) begin
            q_reg <= TW'(qprod >> RS);
        end
        if (state_reg == KS_DIVK && div_done) begin
            x1_reg <= tkf_pkg::sat32(64'(x1sum));
            k_reg  <= div_quo[KW-1:0];
        end
        if (state_reg == KS_WAIT && meas_ok) begin
            diff_reg <= DFW'(meas) - DFW'(x1_reg);
        end
        if (state_reg == KS_MUL2) begin
            cp_reg <= $signed({1'b0, k_reg}) * diff_reg;
            pp_reg <= omk * p1_reg;
        end
    end

    assign done = (state_reg == KS_DONE);
    assign est  = est_reg;

endmodule
`default_nettype wire

/* sv/imu_tilt_kalman_filter.sv */
// The time from input transfer to m_tvalid is set by the later of the tilt path and the
// serial gain division in each Kalman lane; at the default parameters the division ends later.
// One sample is in flight at a time; the next sample is taken in the cycle
// after the result enters the output register, which a stalled result delays.
// Reset: synchronous, active low; clears offsets, estimates to 0 and variances to 4.0.
`default_nettype none
module imu_tilt_kalman_filter #(
    parameter int CORDIC_STEPS  = 16,
    parameter int FRACTION_BITS = 16
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // accel_x_raw, accel_y_raw, accel_z_raw, gyro_x_raw, gyro_y_raw, time_step, zero pad
    input  wire logic [103:0] s_tdata,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // roll_filtered, pitch_filtered, roll_measured, pitch_measured
    output logic [111:0]      m_tdata,
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [2:0]   cfg_index,
    input  wire logic [15:0]  cfg_data
);
    localparam logic [1:0] CS_IDLE = 2'd0;
    localparam logic [1:0] CS_DIFF = 2'd1;
    localparam logic [1:0] CS_SQ   = 2'd2;
    localparam logic [1:0] CS_RUN  = 2'd3;
    localparam int DW = tkf_pkg::DIFF_W;

    logic [1:0] state_reg, state_next;
    logic signed [tkf_pkg::RAW_W-1:0] ax_off_reg, ay_off_reg, az_off_reg;
    logic signed [tkf_pkg::RAW_W-1:0] gx_off_reg, gy_off_reg;
    logic signed [DW-1:0] ax_reg, ay_reg, az_reg, gx_reg, gy_reg;
    logic [tkf_pkg::DT_W-1:0] dt_reg;
    logic [tkf_pkg::SQ_W-1:0] axsq_reg, aysq_reg, azsq_reg;
    logic m_tvalid_reg;
    logic [111:0] m_data_reg;
    logic s_xfer, lane_start, all_done, load_out;
    tkf_pkg::tilt_cmd_t tilt_cmd [tkf_pkg::LANES];
    tkf_pkg::kal_cmd_t  kal_cmd  [tkf_pkg::LANES];
    logic [tkf_pkg::LANES-1:0] tilt_fin, kal_done;
    logic signed [tkf_pkg::ANGLE_W-1:0] angle [tkf_pkg::LANES];
    logic signed [tkf_pkg::EST_W-1:0] est [tkf_pkg::LANES];

    assign cfg_ready  = 1'b1;
    assign s_tready   = (state_reg == CS_IDLE);
    assign s_xfer     = s_tvalid && s_tready;
    assign lane_start = (state_reg == CS_SQ);
    assign all_done   = &kal_done;
    assign load_out   = (state_reg == CS_RUN) && all_done && (!m_tvalid_reg || m_tready);

    // Offset registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ax_off_reg <= '0;
            ay_off_reg <= '0;
            az_off_reg <= '0;
            gx_off_reg <= '0;
            gy_off_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                tkf_pkg::CFG_ACCEL_X_OFFSET: ax_off_reg <= cfg_data;
                tkf_pkg::CFG_ACCEL_Y_OFFSET: ay_off_reg <= cfg_data;
                tkf_pkg::CFG_ACCEL_Z_OFFSET: az_off_reg <= cfg_data;
                tkf_pkg::CFG_GYRO_X_OFFSET:  gx_off_reg <= cfg_data;
                tkf_pkg::CFG_GYRO_Y_OFFSET:  gy_off_reg <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Sequencer: bias removal, squares, lane start, result merge.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            CS_IDLE: if (s_xfer) state_next = CS_DIFF;
            CS_DIFF: state_next = CS_SQ;
            CS_SQ:   state_next = CS_RUN;
            CS_RUN:  if (load_out) state_next = CS_IDLE;
            default: state_next = CS_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= CS_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (load_out) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
        if (s_xfer) begin
            ax_reg <= DW'($signed(s_tdata[15:0])) - DW'(ax_off_reg);
            ay_reg <= DW'($signed(s_tdata[31:16])) - DW'(ay_off_reg);
            az_reg <= DW'($signed(s_tdata[47:32])) - DW'(az_off_reg);
            gx_reg <= DW'($signed(s_tdata[63:48])) - DW'(gx_off_reg);
            gy_reg <= DW'($signed(s_tdata[79:64])) - DW'(gy_off_reg);
            dt_reg <= s_tdata[99:80];
        end
        if (state_reg == CS_DIFF) begin
            axsq_reg <= ax_reg * ax_reg;
            aysq_reg <= ay_reg * ay_reg;
            azsq_reg <= az_reg * az_reg;
        end
        if (load_out) begin
            m_data_reg <= {angle[1][tkf_pkg::MEAS_W-1:0], angle[0][tkf_pkg::MEAS_W-1:0],
                           est[1], est[0]};
        end
    end

    // Lane 0 is roll (gyro x), lane 1 is pitch (gyro y).
    always_comb begin
        tilt_cmd[0].num   = ay_reg;
        tilt_cmd[0].sumsq = tkf_pkg::SUMSQ_W'(axsq_reg) + tkf_pkg::SUMSQ_W'(azsq_reg);
        tilt_cmd[1].num   = -ax_reg;
        tilt_cmd[1].sumsq = tkf_pkg::SUMSQ_W'(aysq_reg) + tkf_pkg::SUMSQ_W'(azsq_reg);
        kal_cmd[0].rate   = gx_reg;
        kal_cmd[0].dt     = dt_reg;
        kal_cmd[1].rate   = gy_reg;
        kal_cmd[1].dt     = dt_reg;
    end

    for (genvar g = 0; g < tkf_pkg::LANES; g++) begin : g_lane
        tkf_tilt #(
            .CORDIC_STEPS  (CORDIC_STEPS),
            .FRACTION_BITS (FRACTION_BITS)
        ) u_tilt (
            .aclk    (aclk),
            .aresetn (aresetn),
            .start   (lane_start),
            .cmd     (tilt_cmd[g]),
            .fin     (tilt_fin[g]),
            .angle   (angle[g])
        );

        tkf_kalman #(
            .FRACTION_BITS (FRACTION_BITS)
        ) u_kalman (
            .aclk    (aclk),
            .aresetn (aresetn),
            .start   (lane_start),
            .cmd     (kal_cmd[g]),
            .meas_ok (tilt_fin[g]),
            .meas    (angle[g]),
            .done    (kal_done[g]),
            .est     (est[g])
        );
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_data_reg;

endmodule
`default_nettype wire

/* sv/tkf_checker.sv */
`default_nettype none
// Port-level checks for the tilt filter.
module tkf_checker (
    input wire logic         aclk,
    input wire logic         aresetn,
    input wire logic         s_tvalid,
    input wire logic         s_tready,
    input wire logic         m_tvalid,
    input wire logic         m_tready,
    input wire logic [111:0] m_tdata
);
    // A stalled result stays offered.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // A stalled result keeps its data.
    a_out_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result data changed while stalled");

    // After reset the block is empty and ready for a sample.
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("bad state after reset");

    // One sample at a time: an input transfer closes the input side.
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second sample taken while busy");

    // A new result frees the input side in the same cycle.
    a_free_on_result: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> s_tready)
        else $error("input not reopened with result");

endmodule

bind imu_tilt_kalman_filter tkf_checker u_tkf_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
`default_nettype wire

/* tb/tb_imu_tilt_kalman_filter.sv */
`default_nettype none
module tb_imu_tilt_kalman_filter;

    // CORDIC angle steps in degrees scaled by 2^24, first sixteen entries.
    localparam longint ANGLE_STEP_Q24 [16] = '{
        754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
        15018523, 7509720, 3754917, 1877466, 938734, 469367,
        234684, 117342, 58671, 29335
    };
    localparam longint ONE_Q16   = 65536;
    localparam longint NINETY_Q16 = 90 * 65536;

    // One tilt result as it leaves the block.
    typedef struct packed {
        logic [23:0] pitch_meas;
        logic [23:0] roll_meas;
        logic [31:0] pitch_est;
        logic [31:0] roll_est;
    } tilt_result_t;

    // Tilt predictor: keeps the bias registers and both Kalman axes, and queues the
    // expected result for every accepted sample.
    class tilt_scoreboard;
        longint       bias [5];
        longint       roll_est, pitch_est;
        longint       roll_pv, pitch_pv;
        tilt_result_t pending [$];
        int           errors;

        function new();
            foreach (bias[i]) bias[i] = 0;
            roll_est  = 0;
            pitch_est = 0;
            roll_pv   = 4 * ONE_Q16;
            pitch_pv  = 4 * ONE_Q16;
            errors    = 0;
        endfunction

        function void write_bias(logic [2:0] idx, logic [15:0] value);
            case (idx)
                tkf_pkg::CFG_ACCEL_X_OFFSET: bias[0] = longint'($signed(value));
                tkf_pkg::CFG_ACCEL_Y_OFFSET: bias[1] = longint'($signed(value));
                tkf_pkg::CFG_ACCEL_Z_OFFSET: bias[2] = longint'($signed(value));
                tkf_pkg::CFG_GYRO_X_OFFSET:  bias[3] = longint'($signed(value));
                tkf_pkg::CFG_GYRO_Y_OFFSET:  bias[4] = longint'($signed(value));
                default: ;
            endcase
        endfunction

        function longint clamp32(longint v);
            if (v > 64'sd2147483647) return 64'sd2147483647;
            if (v < -64'sd2147483648) return -64'sd2147483648;
            return v;
        endfunction

        // Division rounded half away from zero, positive divisor.
        function longint div_round(longint num, longint den);
            longint unsigned mag;
            longint unsigned q;
            mag = (num < 0) ? longint'(-num) : num;
            q = (mag + den / 2) / den;
            return (num < 0) ? -longint'(q) : longint'(q);
        endfunction

        function longint unsigned floor_root(longint unsigned v);
            longint unsigned res;
            longint unsigned b;
            res = 0;
            b = 64'h4000_0000_0000_0000;
            while (b > v) b = b >> 2;
            while (b != 0) begin
                if (v >= res + b) begin
                    v = v - (res + b);
                    res = (res >> 1) + b;
                end else begin
                    res = res >> 1;
                end
                b = b >> 2;
            end
            return res;
        endfunction

        // Accelerometer angle by CORDIC vectoring, rounded to Q16 and clamped to 90 degrees.
        function longint tilt_deg(longint num, longint unsigned sumsq);
            longint unsigned r;
            longint x, y, z, dx, dy;
            r = floor_root(sumsq << 16);
            if (r == 0) return (num > 0) ? NINETY_Q16 : ((num < 0) ? -NINETY_Q16 : 0);
            if (num == 0) return 0;
            x = longint'(r) * 256;
            y = num * 65536;
            z = 0;
            for (int i = 0; i < 16; i++) begin
                dx = y >>> i;
                dy = x >>> i;
                if (y > 0) begin
                    x += dx;
                    y -= dy;
                    z += ANGLE_STEP_Q24[i];
                end else begin
                    x -= dx;
                    y += dy;
                    z -= ANGLE_STEP_Q24[i];
                end
            end
            z = (z + 128) >>> 8;
            if (z > NINETY_Q16) z = NINETY_Q16;
            if (z < -NINETY_Q16) z = -NINETY_Q16;
            return z;
        endfunction

        // One scalar Kalman update: gyro prediction, process noise, gain, correction.
        function void kalman_update(inout longint est, inout longint pv, input longint rate,
                                    input longint dt, input longint meas);
            longint delta, x1, q, p1, k;
            delta = div_round(rate * dt * ONE_Q16, 64'sd131 << 20);
            x1 = clamp32(est + delta);
            q = (dt * dt + (64'sd1 << 19)) >> 20;
            p1 = pv + q;
            if (p1 > 64'sh7FFF_FFFF) p1 = 64'sh7FFF_FFFF;
            k = (p1 << 16) / (p1 + 9 * ONE_Q16);
            est = clamp32(x1 + div_round(k * (meas - x1), ONE_Q16));
            pv = ((ONE_Q16 - k) * p1 + ONE_Q16 / 2) >> 16;
        endfunction

        function void note_sample(logic [103:0] d);
            longint ax, ay, az, gx, gy, dt, rm, pm;
            tilt_result_t res;
            ax = longint'($signed(d[15:0])) - bias[0];
            ay = longint'($signed(d[31:16])) - bias[1];
            az = longint'($signed(d[47:32])) - bias[2];
            gx = longint'($signed(d[63:48])) - bias[3];
            gy = longint'($signed(d[79:64])) - bias[4];
            dt = longint'(d[99:80]);
            rm = tilt_deg(ay, ax * ax + az * az);
            pm = tilt_deg(-ax, ay * ay + az * az);
            kalman_update(roll_est, roll_pv, gx, dt, rm);
            kalman_update(pitch_est, pitch_pv, gy, dt, pm);
            res.roll_est   = roll_est[31:0];
            res.pitch_est  = pitch_est[31:0];
            res.roll_meas  = rm[23:0];
            res.pitch_meas = pm[23:0];
            pending.push_back(res);
        endfunction

        function void check_result(tilt_result_t got);
            tilt_result_t want;
            if (pending.size() == 0) begin
                $error("unexpected result transfer %h", got);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.roll_est !== want.roll_est) begin
                $error("roll_filtered expected %h actual %h", want.roll_est, got.roll_est);
                errors++;
            end
            if (got.pitch_est !== want.pitch_est) begin
                $error("pitch_filtered expected %h actual %h", want.pitch_est, got.pitch_est);
                errors++;
            end
            if (got.roll_meas !== want.roll_meas) begin
                $error("roll_measured expected %h actual %h", want.roll_meas, got.roll_meas);
                errors++;
            end
            if (got.pitch_meas !== want.pitch_meas) begin
                $error("pitch_measured expected %h actual %h", want.pitch_meas,
                       got.pitch_meas);
                errors++;
            end
        endfunction
    endclass

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [103:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [111:0] m_tdata;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [2:0]   cfg_index = '0;
    logic [15:0]  cfg_data = '0;

    tilt_scoreboard sb = new();
    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    imu_tilt_kalman_filter u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #5 aclk = ~aclk;

    // Observe every transfer on the three channels.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) sb.note_sample(s_tdata);
            if (m_tvalid && m_tready) sb.check_result(tilt_result_t'(m_tdata));
            if (cfg_valid && cfg_ready) sb.write_bias(cfg_index, cfg_data);
        end
    end

    // Result side back-pressure.
    always @(posedge aclk) begin
        m_tready <= (recv_stall_pct == 0) ? 1'b1 : ($urandom_range(99) >= recv_stall_pct);
    end

    function automatic logic [103:0] pack_sample(logic [15:0] ax, logic [15:0] ay,
                                                 logic [15:0] az, logic [15:0] gx,
                                                 logic [15:0] gy, logic [19:0] dt);
        return {4'b0, dt, gy, gx, az, ay, ax};
    endfunction

    task automatic send_sample(input logic [103:0] d);
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(99) < send_idle_pct) @(posedge aclk);
        end
        s_tdata  <= d;
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // Writes can follow back to back; end_writes closes the channel afterwards.
    task automatic write_reg(input logic [2:0] idx, input logic [15:0] value);
        cfg_index <= idx;
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
    endtask

    task automatic end_writes();
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // Let every expected result arrive, then give the block its latency.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (150) @(posedge aclk);
    endtask

    // Random sample: mostly a plausible attitude at a realistic rate, some raw noise, some zeroed axes.
    function automatic logic [103:0] random_sample();
        int kind;
        kind = $urandom_range(99);
        if (kind < 70) begin
            return pack_sample(16'($urandom_range(8192) - 4096),
                               16'($urandom_range(8192) - 4096),
                               16'($urandom_range(8192) - 4096),
                               16'($urandom_range(4000) - 2000),
                               16'($urandom_range(4000) - 2000),
                               20'($urandom_range(2000, 500)));
        end else if (kind < 90) begin
            return pack_sample(16'($urandom), 16'($urandom), 16'($urandom),
                               16'($urandom), 16'($urandom), 20'($urandom));
        end else begin
            // Axes zeroed at random to reach the degenerate angle cases.
            return pack_sample($urandom_range(1) ? 16'($urandom) : 16'h0,
                               $urandom_range(1) ? 16'($urandom) : 16'h0,
                               $urandom_range(1) ? 16'($urandom) : 16'h0,
                               16'($urandom), 16'($urandom),
                               $urandom_range(1) ? 20'($urandom_range(3000)) : 20'h0);
        end
    endfunction

    initial begin
        logic [15:0] fill;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed samples at reset biases.
        send_sample(pack_sample(16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 20'h0));
        send_sample(pack_sample(16'h0, 16'd4096, 16'h0, 16'd131, 16'd131, 20'd1049));
        send_sample(pack_sample(16'h0, -16'sd4096, 16'h0, -16'sd131, 16'h0, 20'd1049));
        send_sample(pack_sample(16'h0, 16'h0, 16'd4096, 16'h0, 16'h0, 20'd1049));
        send_sample(pack_sample(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
                                20'hFFFFF));
        send_sample(pack_sample(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 20'h0));
        send_sample(pack_sample(16'h8000, 16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF, 20'd1));
        send_sample(pack_sample(16'd100, -16'sd200, 16'd4000, 16'd500, -16'sd500,
                                20'd2000));
        send_sample(pack_sample(16'h7FFF, 16'h0, 16'h0, 16'h7FFF, 16'h8000, 20'hFFFFF));
        send_sample(pack_sample(16'h8000, 16'h0, 16'h0, 16'h8000, 16'h7FFF, 20'hFFFFF));
        send_sample(pack_sample(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555,
                                20'hAAAAA));
        drain();

        // Phases of bias settings and idling patterns.
        for (int p = 0; p < 6; p++) begin
            for (int r = 0; r < 5; r++) begin
                case (p)
                    0: fill = 16'h0000;
                    1: fill = 16'h7FFF;
                    2: fill = 16'h8000;
                    default: fill = 16'($urandom_range(600)) - 16'd300;
                endcase
                write_reg(3'(r), fill);
            end
            write_reg(3'($urandom_range(7, 5)), 16'($urandom));
            end_writes();
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 86; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 86; end
                default: begin send_idle_pct = 9; recv_stall_pct = 9; end
            endcase
            for (int n = 0; n < 190; n++) send_sample(random_sample());
            drain();
            recv_stall_pct = 0;
        end

        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // Watchdog.
    initial begin
        #20000000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
`default_nettype wire
